@@ rtl/mexp_pkg.sv @@
// Shared types, constants and microcode ROM for the modular exponentiation block.
package mexp_pkg;

  localparam int unsigned EXP_BITS = 31;
  localparam int unsigned CNT_W    = $clog2(EXP_BITS + 1);
  localparam int unsigned RES_W    = 30;
  localparam int unsigned EXPO_W   = 31;

  localparam logic [RES_W-1:0] PRIME    = 30'd1000000007;
  // floor(2^60 / PRIME), Barrett constant
  localparam logic [30:0]      BARRETT_MU = 31'd1152921496;

  typedef logic [2:0] step_t;

  localparam step_t STEP_WAIT = 3'd0;
  localparam step_t STEP_TEST = 3'd1;
  localparam step_t STEP_BIT  = 3'd2;
  localparam step_t STEP_MUL  = 3'd3;
  localparam step_t STEP_SQR  = 3'd4;
  localparam step_t STEP_DONE = 3'd5;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_BUSY,
    COND_FIN,
    COND_BIT_CLR
  } cond_e;

  typedef enum logic {
    DEST_ACC,
    DEST_PW
  } dest_e;

  typedef struct packed {
    cond_e cond;
    step_t target;
    logic  mul;
    logic  sqr;
    logic  finish;
  } ucode_t;

  typedef struct packed {
    logic mul;
    logic sqr;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic fin;
    logic bit0;
    logic mul_busy;
  } stat_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{cond: COND_NEXT, target: STEP_WAIT, mul: 1'b0, sqr: 1'b0, finish: 1'b0};
    case (s)
      STEP_WAIT: w.cond = COND_BUSY;
      STEP_TEST: begin
        w.cond   = COND_FIN;
        w.target = STEP_DONE;
      end
      STEP_BIT: begin
        w.cond   = COND_BIT_CLR;
        w.target = STEP_SQR;
      end
      STEP_MUL: w.mul = 1'b1;
      STEP_SQR: begin
        w.sqr    = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
      STEP_DONE: w.finish = 1'b1;
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/mexp_mulmod.sv @@
// Six-stage pipelined 30x30 multiplier with Barrett reduction modulo the prime.
module mexp_mulmod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [mexp_pkg::RES_W-1:0] a_i,
  input  logic [mexp_pkg::RES_W-1:0] b_i,
  input  mexp_pkg::dest_e            dest_i,
  output logic                       valid_o,
  output logic [mexp_pkg::RES_W-1:0] res_o,
  output mexp_pkg::dest_e            dest_o,
  output logic                       busy_o
);

  logic [5:0]            v_q;
  mexp_pkg::dest_e       dest_q [6];
  logic [59:0]           prod_q;
  logic [61:0]           est_q;
  logic [31:0]           x1_q, x2_q;
  logic [31:0]           qp_q;
  logic [31:0]           r3_q;
  logic [30:0]           r4_q;
  logic [29:0]           r5_q;
  logic [30:0]           quot;
  logic [31:0]           r3_d;
  logic [29:0]           r5_d;

  assign quot = est_q[61:31];
  assign r3_d = x2_q - qp_q;                        // true remainder < 3P < 2^32
  assign r5_d = (r4_q >= 31'(mexp_pkg::PRIME)) ? 30'(r4_q - 31'(mexp_pkg::PRIME))
                                                 : r4_q[29:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q[0] <= dest_i;
    for (int i = 1; i < 6; i++) begin
      dest_q[i] <= dest_q[i-1];
    end
    prod_q <= 60'(a_i) * 60'(b_i);
    est_q  <= 62'(prod_q[59:29]) * 62'(mexp_pkg::BARRETT_MU);
    x1_q   <= prod_q[31:0];
    qp_q   <= 32'(64'(quot) * 64'(mexp_pkg::PRIME));
    x2_q   <= x1_q;
    r3_q   <= r3_d;
    r4_q   <= (r3_q >= 32'(mexp_pkg::PRIME)) ? 31'(r3_q - 32'(mexp_pkg::PRIME))
                                               : r3_q[30:0];
    r5_q   <= r5_d;
  end

  assign valid_o = v_q[5];
  assign res_o   = r5_q;
  assign dest_o  = dest_q[5];
  assign busy_o  = |v_q;

endmodule

@@ rtl/mexp_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module mexp_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mexp_pkg::stat_t stat_i,
  output logic            accept_o,
  output logic            busy_o,
  output mexp_pkg::ctrl_t ctrl_o
);

  logic              busy_q, busy_d;
  mexp_pkg::step_t   step_q, step_d;
  mexp_pkg::ucode_t  word;
  logic              take;

  assign word     = mexp_pkg::ucode_rom(step_q);
  assign accept_o = start_i & ~busy_q;
  assign busy_o   = busy_q;

  always_comb begin
    case (word.cond)
      mexp_pkg::COND_NEXT:    take = 1'b0;
      mexp_pkg::COND_ALWAYS:  take = 1'b1;
      mexp_pkg::COND_BUSY:    take = stat_i.mul_busy;
      mexp_pkg::COND_FIN:     take = stat_i.fin;
      mexp_pkg::COND_BIT_CLR: take = ~stat_i.bit0;
      default:                take = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = mexp_pkg::STEP_WAIT;
      end
    end else if (word.finish) begin
      busy_d = 1'b0;
      step_d = mexp_pkg::STEP_WAIT;
    end else begin
      step_d = take ? word.target : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= mexp_pkg::STEP_WAIT;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign ctrl_o.mul    = busy_q & word.mul;
  assign ctrl_o.sqr    = busy_q & word.sqr;
  assign ctrl_o.finish = busy_q & word.finish;

endmodule

@@ rtl/modular_exponentiation.sv @@
// Top level: base^exponent mod 1000000007 by right-to-left square-and-multiply.
// Each exponent bit up to the highest set bit costs a round trip through the 6-stage modular
// multiplier; for a set bit the multiply and the square enter it back to back.
// Throughput: one request at a time; busy_o is high from acceptance to the result.
// Reset (rst_ni, async, active low) idles the sequencer and clears done_o.
// done_o marks residue_o for exactly one cycle; the receiver cannot stall.
module modular_exponentiation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [mexp_pkg::RES_W-1:0]  base_i,
  input  logic [mexp_pkg::EXPO_W-1:0] exponent_i,
  output logic                        done_o,
  output logic [mexp_pkg::RES_W-1:0]  residue_o
);

  // Datapath registers: running result, current power, remaining exponent, bit count
  logic [mexp_pkg::RES_W-1:0]  acc_q;
  logic [mexp_pkg::RES_W-1:0]  pw_q;
  logic [mexp_pkg::EXPO_W-1:0] ex_q;
  logic [mexp_pkg::CNT_W-1:0]  cnt_q;
  logic                        done_q;
  logic [mexp_pkg::RES_W-1:0]  residue_q;

  logic                        accept;
  mexp_pkg::ctrl_t             ctrl;
  mexp_pkg::stat_t             stat;

  logic                        mm_valid;
  logic [mexp_pkg::RES_W-1:0]  mm_res;
  mexp_pkg::dest_e             mm_dest;
  logic                        mm_busy;
  logic [mexp_pkg::RES_W-1:0]  base_red;

  // base < 2^30 < 2P, so one conditional subtract reduces it
  assign base_red = (base_i >= mexp_pkg::PRIME) ? base_i - mexp_pkg::PRIME : base_i;

  // Scan ends when the bit count runs out or no set bits remain
  assign stat.fin      = (cnt_q == '0) | (ex_q == '0);
  assign stat.bit0     = ex_q[0];
  assign stat.mul_busy = mm_busy;

  mexp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .stat_i   (stat),
    .accept_o (accept),
    .busy_o   (busy_o),
    .ctrl_o   (ctrl)
  );

  // Multiply step issues acc*pw, square step issues pw*pw; both read the old power
  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ctrl.mul | ctrl.sqr),
    .a_i     (ctrl.mul ? acc_q : pw_q),
    .b_i     (pw_q),
    .dest_i  (ctrl.sqr ? mexp_pkg::DEST_PW : mexp_pkg::DEST_ACC),
    .valid_o (mm_valid),
    .res_o   (mm_res),
    .dest_o  (mm_dest),
    .busy_o  (mm_busy)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= mexp_pkg::RES_W'(1);
      pw_q  <= base_red;
      ex_q  <= exponent_i;
      cnt_q <= mexp_pkg::CNT_W'(mexp_pkg::EXP_BITS);
    end else begin
      if (ctrl.sqr) begin
        ex_q  <= ex_q >> 1;
        cnt_q <= cnt_q - mexp_pkg::CNT_W'(1);
      end
      if (mm_valid) begin
        if (mm_dest == mexp_pkg::DEST_PW) begin
          pw_q <= mm_res;
        end else begin
          acc_q <= mm_res;
        end
      end
    end
    if (ctrl.finish) begin
      residue_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl.finish;
    end
  end

  assign done_o    = done_q;
  assign residue_o = residue_q;

endmodule

@@ rtl/mexp_checker.sv @@
// Port-level checker for the modular exponentiation block, bound to the top level.
module mexp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [mexp_pkg::RES_W-1:0]  base_i,
  input logic [mexp_pkg::EXPO_W-1:0] exponent_i,
  input logic                        done_o,
  input logic [mexp_pkg::RES_W-1:0]  residue_o
);

  logic unused_in;
  assign unused_in = ^{base_i, exponent_i};

  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (residue_o < mexp_pkg::PRIME))
    else $error("residue not below the prime");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  a_done_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) && !busy_o))
    else $error("result without a request in flight");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in a row");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

@@ sim/tb_modular_exponentiation.sv @@
// Testbench for modular_exponentiation: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb_modular_exponentiation;

  // Modulus as a 64-bit value so products of two residues fit without overflow.
  localparam longint unsigned MODULUS = 64'd1000000007;
  localparam logic [mexp_pkg::RES_W-1:0] BASE_MAX = '1;
  localparam logic [mexp_pkg::EXPO_W-1:0] EXPO_MAX = '1;
  // Settling margin sized for the worst request, with every scanned bit set.
  localparam int unsigned SETTLE_CYCLES = mexp_pkg::EXP_BITS * 11 + 10;
  localparam int unsigned RANDOM_REQUESTS = 1600;
  localparam int unsigned MAX_REPORTED = 10;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [mexp_pkg::RES_W-1:0]    base_i;
  logic [mexp_pkg::EXPO_W-1:0]   exponent_i;
  logic                          done_o;
  logic [mexp_pkg::RES_W-1:0]    residue_o;

  // Residues still owed by the block, oldest first.
  logic [mexp_pkg::RES_W-1:0]    expected_residues[$];
  int unsigned                   fault_count;

  modular_exponentiation u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .done_o     (done_o),
    .residue_o  (residue_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // base^exponent mod prime, right-to-left square-and-multiply over the scanned bits.
  // Base is reduced first; exponent bits at or above EXP_BITS are not looked at.
  function automatic logic [mexp_pkg::RES_W-1:0] power_mod_prime(
    input logic [mexp_pkg::RES_W-1:0]  base,
    input logic [mexp_pkg::EXPO_W-1:0] expo);
    longint unsigned power;
    longint unsigned acc;
    power = longint'(base) % MODULUS;
    acc   = 1;
    for (int i = 0; i < mexp_pkg::EXP_BITS && i < mexp_pkg::EXPO_W; i++) begin
      if (expo[i]) acc = (acc * power) % MODULUS;
      power = (power * power) % MODULUS;
    end
    return acc[mexp_pkg::RES_W-1:0];
  endfunction

  // Present one request and hold it until the block takes it.
  // Called at a rising edge; returns at the edge where the request was accepted.
  // start_i is left high so a following request goes out without a bubble.
  task automatic issue_request(input logic [mexp_pkg::RES_W-1:0]  base,
                               input logic [mexp_pkg::EXPO_W-1:0] expo);
    start_i    <= 1'b1;
    base_i     <= base;
    exponent_i <= expo;
    // busy_o read right after the edge is its value before the edge
    do @(posedge clk_i); while (busy_o);
    expected_residues.push_back(power_mod_prime(base, expo));
  endtask

  // Drop start and let the sender sit idle for a while.
  task automatic sender_gap(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Zero exponent gives 1 whatever the base, 0^0 and multiples of the prime included.
  task automatic test_zero_exponent();
    issue_request('0, '0);
    issue_request(mexp_pkg::PRIME, '0);
    issue_request(BASE_MAX, '0);
    issue_request(30'd12345, '0);
    sender_gap(3);
  endtask

  // Field extremes, bases at and above the prime, and a few identities:
  // Fermat (a^(p-1) = 1), inverse (a^(p-2)), and (p-1)^2 = 1.
  task automatic test_operand_extremes();
    issue_request('0, 31'd1);
    issue_request('0, EXPO_MAX);
    issue_request(30'd1, EXPO_MAX);
    issue_request(BASE_MAX, 31'd1);
    issue_request(BASE_MAX, EXPO_MAX);
    issue_request(mexp_pkg::PRIME - 30'd1, EXPO_MAX);
    issue_request(mexp_pkg::PRIME - 30'd1, 31'd2);
    issue_request(mexp_pkg::PRIME, 31'd5);
    issue_request(mexp_pkg::PRIME + 30'd1, EXPO_MAX);
    issue_request(30'd2, 31'd30);
    issue_request(30'd2, 31'h4000_0000);
    issue_request(30'd2, 31'd1000000006);
    issue_request(30'd3, 31'd1000000005);
    issue_request(30'h2AAA_AAAA, 31'h5555_5555);
    issue_request(30'h1555_5555, 31'h2AAA_AAAA);
    sender_gap(2);
  endtask

  // Random bases and exponents of random bit length, in bursts with random gaps.
  // Gaps can end while the previous request is still in its bit loop.
  task automatic test_random_requests();
    int unsigned                  sent;
    int unsigned                  burst;
    int unsigned                  width;
    logic [31:0]                  mask;
    logic [mexp_pkg::RES_W-1:0]   base;
    logic [mexp_pkg::EXPO_W-1:0]  expo;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0:       base = mexp_pkg::PRIME - 30'd2 + 30'($urandom_range(0, 4));
          1:       base = 30'($urandom_range(0, 3));
          2:       base = BASE_MAX - 30'($urandom_range(0, 3));
          default: base = 30'($urandom());
        endcase
        // bit length 0..31, top bit of that length forced on
        width = $urandom_range(0, mexp_pkg::EXPO_W);
        mask  = (32'd1 << width) - 32'd1;
        expo  = 31'($urandom() & mask);
        if (width != 0) expo[width-1] = 1'b1;
        issue_request(base, expo);
        sent++;
      end
      // about a third of the bursts run straight into the next one
      if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 40));
    end
    sender_gap(1);
  endtask

  // Every strobed residue must match the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_residue
    logic [mexp_pkg::RES_W-1:0] want;
    if (rst_ni && done_o) begin
      if (expected_residues.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTED)
          $display("%0t: unexpected result, residue %0d", $realtime, residue_o);
      end else begin
        want = expected_residues.pop_front();
        if (residue_o !== want) begin
          fault_count++;
          if (fault_count <= MAX_REPORTED)
            $display("%0t: residue mismatch, expected %0d got %0d", $realtime, want,
                     residue_o);
        end
      end
    end
  end

  initial begin
    fault_count = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    base_i      = '0;
    exponent_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_exponent();
    test_operand_extremes();
    test_random_requests();

    // drain, then give a stray late result time to show up
    while (expected_residues.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fault_count == 0 && expected_residues.size() == 0) begin
      $display("modular_exponentiation test passed");
    end else begin
      $display("modular_exponentiation test failed");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("modular_exponentiation test failed");
    $finish;
  end

endmodule
